>>> rtl/somdt_pkg.sv
// ----------------------------------------------------------------------------
// somdt_pkg
// Shared constants for the span occlusion max depth tree.
// ----------------------------------------------------------------------------
`default_nettype none

package somdt_pkg;

	localparam int LEAVES      = 128;
	localparam int SAMPLE_COLS = 80;
	localparam int COL_STRIDE  = 4;
	localparam int VIEW_COLS   = 320;

	localparam int NODE_COUNT  = 2 * LEAVES;
	localparam int NODE_W      = $clog2(NODE_COUNT);
	localparam int DEPTH_W     = 16;
	localparam int PIX_W       = 16;
	localparam int COL_W       = 7;

	typedef logic [NODE_W-1:0]  node_t;
	typedef logic [NODE_W:0]    span_idx_t;
	typedef logic [DEPTH_W-1:0] depth_t;

endpackage

`default_nettype wire

>>> rtl/span_occlusion_max_depth_tree_unit.sv
// ----------------------------------------------------------------------------
// span_occlusion_max_depth_tree_unit
// Max segment tree over sampled wall depths; answers sprite span occlusion.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. After reset the tree
// memory is swept to zero, one node a cycle, and busy stays high until every
// node has been cleared. A write to a sampled column stores the leaf, then
// walks up one tree level at a time, folding the sibling read on the step
// before into the parent, until the root is written. A write to an unsampled
// column is dropped at once; busy never rises. A query walks the tree bottom
// up with the single read port, reading on each level the left bound node,
// then the right bound node; the clamped span never reaches beyond sampled
// column 79, and the walk stops below the root. Spans off screen or covering
// no column end the walk at its first step. The result shows on visible and
// span_max_depth for one cycle with done, the cycle after the walk ends, and
// must be taken then. Writes give no result.
// ----------------------------------------------------------------------------
`default_nettype none

module span_occlusion_max_depth_tree_unit (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           start,
	output logic                          busy,
	input  wire                           action,
	input  wire  [somdt_pkg::COL_W-1:0]   column,
	input  wire  [somdt_pkg::DEPTH_W-1:0] wall_depth,
	input  wire  [somdt_pkg::PIX_W-1:0]   span_left,
	input  wire  [somdt_pkg::PIX_W-1:0]   span_right,
	input  wire  [somdt_pkg::DEPTH_W-1:0] sprite_depth,
	output logic                          done,
	output logic                          visible,
	output logic [somdt_pkg::DEPTH_W-1:0] span_max_depth
);
	import somdt_pkg::*;

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_WLEAF = 3'd2;
	localparam logic [2:0] S_WUP   = 3'd3;
	localparam logic [2:0] S_QLO   = 3'd4;
	localparam logic [2:0] S_QHI   = 3'd5;

	localparam logic signed [PIX_W-1:0] VIEW_S    = PIX_W'(VIEW_COLS);
	localparam logic        [PIX_W-1:0] VIEW_LAST = PIX_W'(VIEW_COLS - 1);
	localparam logic        [PIX_W-1:0] LEAF_LAST = PIX_W'(LEAVES - 1);
	localparam node_t                   ROOT      = node_t'(1);

	depth_t mem [NODE_COUNT];
	depth_t rdata_q;

	logic [2:0] state_q;
	node_t      clr_q;
	node_t      node_q;
	depth_t     cur_q;
	span_idx_t  lo_q;
	span_idx_t  hi_q;
	depth_t     best_q;
	depth_t     sdepth_q;
	logic       pend_q;

	logic       we;
	node_t      waddr;
	depth_t     wdata;
	node_t      raddr;

	logic       accept;
	logic       off_screen;
	logic [PIX_W-1:0] left_c, right_c, first_col, last_raw, last_col;
	logic       empty;
	depth_t     up_max;
	node_t      parent;
	depth_t     best_n;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// span clamping and column mapping
	always_comb begin
		off_screen = $signed(span_right) < 0 || $signed(span_left) >= VIEW_S;
		left_c     = span_left[PIX_W-1] ? '0 : span_left;
		right_c    = ($signed(span_right) >= VIEW_S) ? VIEW_LAST : span_right;
		first_col  = PIX_W'(left_c / COL_STRIDE);
		last_raw   = PIX_W'(right_c / COL_STRIDE);
		last_col   = (last_raw > LEAF_LAST) ? LEAF_LAST : last_raw;
		empty      = off_screen || (first_col > last_col);
	end

	always_comb begin
		parent = node_q >> 1;
		up_max = (rdata_q > cur_q) ? rdata_q : cur_q;
		best_n = (pend_q && rdata_q > best_q) ? rdata_q : best_q;
	end

	// memory port control
	always_comb begin
		we    = 1'b0;
		waddr = node_q;
		wdata = cur_q;
		raddr = node_q ^ node_t'(1);
		case (state_q)
			S_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			S_WLEAF: begin
				we = 1'b1;
			end
			S_WUP: begin
				we    = 1'b1;
				waddr = parent;
				wdata = up_max;
				raddr = parent ^ node_t'(1);
			end
			S_QLO: begin
				raddr = lo_q[NODE_W-1:0];
			end
			S_QHI: begin
				raddr = hi_q[NODE_W-1:0];
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			pend_q  <= 1'b0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + node_t'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (action) begin
							state_q <= S_QLO;
							pend_q  <= 1'b0;
						end else if (32'(column) < SAMPLE_COLS && 32'(column) < LEAVES) begin
							state_q <= S_WLEAF;
						end
					end
				end
				S_WLEAF: begin
					state_q <= S_WUP;
				end
				S_WUP: begin
					if (parent == ROOT) begin
						state_q <= S_IDLE;
					end
				end
				S_QLO: begin
					if (lo_q > hi_q) begin
						state_q <= S_IDLE;
						done    <= 1'b1;
					end else begin
						state_q <= S_QHI;
						pend_q  <= lo_q[0];
					end
				end
				S_QHI: begin
					state_q <= S_QLO;
					pend_q  <= !hi_q[0];
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				node_q   <= node_t'(LEAVES) + node_t'(column);
				cur_q    <= wall_depth;
				sdepth_q <= sprite_depth;
				best_q   <= '0;
				if (empty) begin
					lo_q <= span_idx_t'(1);
					hi_q <= '0;
				end else begin
					lo_q <= span_idx_t'(first_col) + span_idx_t'(LEAVES);
					hi_q <= span_idx_t'(last_col) + span_idx_t'(LEAVES);
				end
			end
			S_WUP: begin
				node_q <= parent;
				cur_q  <= up_max;
			end
			S_QLO: begin
				best_q <= best_n;
				if (lo_q > hi_q) begin
					visible        <= sdepth_q < best_n;
					span_max_depth <= best_n;
				end
			end
			S_QHI: begin
				best_q <= best_n;
				lo_q   <= (lo_q + span_idx_t'(lo_q[0])) >> 1;
				hi_q   <= (hi_q - span_idx_t'(!hi_q[0])) >> 1;
			end
			default: begin
				best_q <= best_q;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/somdt_chk.sv
// ----------------------------------------------------------------------------
// somdt_chk
// Port level checks for the span occlusion max depth tree, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module somdt_chk (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           start,
	input wire                           busy,
	input wire                           action,
	input wire [somdt_pkg::COL_W-1:0]    column,
	input wire [somdt_pkg::DEPTH_W-1:0]  wall_depth,
	input wire [somdt_pkg::PIX_W-1:0]    span_left,
	input wire [somdt_pkg::PIX_W-1:0]    span_right,
	input wire [somdt_pkg::DEPTH_W-1:0]  sprite_depth,
	input wire                           done,
	input wire                           visible,
	input wire [somdt_pkg::DEPTH_W-1:0]  span_max_depth
);
	import somdt_pkg::*;

	// a query item that is taken raises busy
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && action |=> busy)
		else $error("query item did not raise busy");

	// no result can appear in the cycle right after an item is taken
	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !done)
		else $error("result in the cycle after an item was taken");

	// visible needs a wall deeper than the sprite, hence a non-zero maximum
	a_visible_depth: assert property (@(posedge clk) disable iff (!arst_n)
		done && visible |-> span_max_depth != '0)
		else $error("visible result with zero span maximum");

	// span entirely left of the screen gives an empty result
	a_off_screen: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && action && span_right[PIX_W-1]
		|-> ##2 (done && !visible && span_max_depth == '0))
		else $error("off screen span gave a wrong result");

endmodule

bind span_occlusion_max_depth_tree_unit somdt_chk u_somdt_chk (.*);

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for span_occlusion_max_depth_tree_unit: column writes and
// sprite span queries are mirrored in a per-column depth table, and every done
// strobe is compared with the predicted visibility and span maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import somdt_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 40;
	localparam int IDLE_PCT     = 32;

	typedef enum logic {
		ACT_WRITE = 1'b0,
		ACT_QUERY = 1'b1
	} action_e;

	typedef struct packed {
		action_e           action;
		logic [COL_W-1:0]  column;
		depth_t            wall_depth;
		logic [PIX_W-1:0]  span_left;
		logic [PIX_W-1:0]  span_right;
		depth_t            sprite_depth;
	} tree_item_t;

	typedef struct packed {
		logic   visible;
		depth_t span_max_depth;
	} occlusion_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                action;
	logic [COL_W-1:0]    column;
	depth_t              wall_depth;
	logic [PIX_W-1:0]    span_left;
	logic [PIX_W-1:0]    span_right;
	depth_t              sprite_depth;
	logic                done;
	logic                visible;
	depth_t              span_max_depth;

	depth_t      col_depth [LEAVES];
	occlusion_t  pending_occlusions [$];
	int          error_count;
	int          cycle_count;
	bit          idle_on;

	span_occlusion_max_depth_tree_unit uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.action         (action),
		.column         (column),
		.wall_depth     (wall_depth),
		.span_left      (span_left),
		.span_right     (span_right),
		.sprite_depth   (sprite_depth),
		.done           (done),
		.visible        (visible),
		.span_max_depth (span_max_depth)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Mirror one accepted item: writes update the column table, queries
	// queue the expected answer.
	task automatic track_occlusion(input tree_item_t it);
		int         lo;
		int         hi;
		int         first;
		int         last;
		depth_t     best;
		occlusion_t res;
		if (it.action == ACT_WRITE) begin
			if (it.column < SAMPLE_COLS && it.column < LEAVES)
				col_depth[it.column] = it.wall_depth;
			return;
		end
		lo   = $signed(it.span_left);
		hi   = $signed(it.span_right);
		best = '0;
		if (hi >= 0 && lo < VIEW_COLS) begin
			if (lo < 0)
				lo = 0;
			if (hi >= VIEW_COLS)
				hi = VIEW_COLS - 1;
			first = lo / COL_STRIDE;
			last  = hi / COL_STRIDE;
			if (last >= LEAVES)
				last = LEAVES - 1;
			for (int c = first; c <= last; c++)
				if (col_depth[c] > best)
					best = col_depth[c];
		end
		res.visible        = (it.sprite_depth < best);
		res.span_max_depth = best;
		pending_occlusions.push_back(res);
	endtask

	task automatic send_item(input tree_item_t it);
		int gap;
		start        <= 1'b1;
		action       <= it.action;
		column       <= it.column;
		wall_depth   <= it.wall_depth;
		span_left    <= it.span_left;
		span_right   <= it.span_right;
		sprite_depth <= it.sprite_depth;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		track_occlusion(it);
		if (idle_on && $urandom_range(99) < IDLE_PCT) begin
			start <= 1'b0;
			gap = $urandom_range(1, 5);
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic tree_item_t write_item(input int col, input int depth);
		tree_item_t it;
		it.action       = ACT_WRITE;
		it.column       = col[COL_W-1:0];
		it.wall_depth   = depth[DEPTH_W-1:0];
		it.span_left    = PIX_W'($urandom());
		it.span_right   = PIX_W'($urandom());
		it.sprite_depth = DEPTH_W'($urandom());
		return it;
	endfunction

	function automatic tree_item_t query_item(input int lo, input int hi, input int depth);
		tree_item_t it;
		it.action       = ACT_QUERY;
		it.column       = COL_W'($urandom());
		it.wall_depth   = DEPTH_W'($urandom());
		it.span_left    = lo[PIX_W-1:0];
		it.span_right   = hi[PIX_W-1:0];
		it.sprite_depth = depth[DEPTH_W-1:0];
		return it;
	endfunction

	// Freshly cleared tree: everything reads zero, nothing visible
	task automatic test_empty_tree();
		send_item(query_item(0, VIEW_COLS - 1, 0));
		send_item(query_item(-32768, 32767, 0));
	endtask

	task automatic test_column_writes();
		send_item(write_item(0, 16'hFFFF));
		send_item(write_item(SAMPLE_COLS - 1, 1000));
		send_item(write_item(SAMPLE_COLS, 16'hFFFF));   // unsampled, dropped
		send_item(write_item(LEAVES - 1, 16'hFFFF));    // unsampled, dropped
		send_item(write_item(40, 0));
		send_item(write_item(41, 500));
		send_item(query_item(0, VIEW_COLS - 1, 16'hFFFF));
		send_item(query_item(4, VIEW_COLS - 1, 999));
		send_item(query_item(4, VIEW_COLS - 1, 1000));   // equal depth hides it
		send_item(query_item(160, 163, 0));              // one zero column
		send_item(query_item(164, 167, 499));
	endtask

	task automatic test_span_clipping();
		send_item(query_item(-5, -1, 0));                // wholly left
		send_item(query_item(VIEW_COLS, 32767, 0));      // wholly right
		send_item(query_item(-32768, 0, 0));             // clamped to column 0
		send_item(query_item(VIEW_COLS - 1, 32767, 0));  // clamped to last column
		send_item(query_item(200, 100, 0));              // reversed
		send_item(query_item(3, 0, 0));                  // reversed within a column
		send_item(query_item(-32768, -32768, 0));
		send_item(query_item(32767, -32768, 0));
		send_item(query_item(0, 3, 16'hFFFE));
	endtask

	task automatic test_random_traffic(input int count);
		tree_item_t it;
		int         lo;
		int         hi;
		int         dep;
		int         sel;
		for (int n = 0; n < count; n++) begin
			// long stretch without gaps first, then random idling
			idle_on = (n >= count / 3);
			if ($urandom_range(99) < 40) begin
				sel = $urandom_range(99);
				if (sel < 60)
					dep = $urandom_range(0, 16'hFFFF);
				else if (sel < 80)
					dep = $urandom_range(0, 15);
				else
					dep = $urandom_range(0, 1) ? 16'hFFFF : 0;
				if ($urandom_range(99) < 80)
					it = write_item($urandom_range(0, SAMPLE_COLS - 1), dep);
				else
					it = write_item($urandom_range(SAMPLE_COLS, LEAVES - 1), dep);
			end else begin
				sel = $urandom_range(99);
				if (sel < 70) begin
					lo = $urandom_range(0, VIEW_COLS + 80) - 40;
					hi = lo + $urandom_range(0, 140) - 12;
				end else if (sel < 85) begin
					lo = $urandom_range(0, 16'hFFFF);
					hi = $urandom_range(0, 16'hFFFF);
				end else begin
					lo = $urandom_range(0, 1) ? $urandom_range(0, 8) - 4
					                          : VIEW_COLS - 4 + $urandom_range(0, 8);
					hi = lo + $urandom_range(0, 8);
				end
				if ($urandom_range(1))
					dep = $urandom_range(0, 16'hFFFF);
				else
					dep = col_depth[$urandom_range(0, SAMPLE_COLS - 1)]
					      + $urandom_range(0, 2) - 1;
				it = query_item(lo, hi, dep);
			end
			send_item(it);
		end
	endtask

	// Result checker: done is a one-cycle strobe, no back-pressure possible
	always @(posedge clk) begin
		occlusion_t exp_res;
		if (arst_n && done) begin
			if (pending_occlusions.size() == 0) begin
				$error("unexpected result: visible %0d span_max_depth %0d",
				       visible, span_max_depth);
				error_count++;
			end else begin
				exp_res = pending_occlusions.pop_front();
				if (visible !== exp_res.visible) begin
					$error("visible: expected %0d, actual %0d", exp_res.visible, visible);
					error_count++;
				end
				if (span_max_depth !== exp_res.span_max_depth) begin
					$error("span_max_depth: expected %0d, actual %0d",
					       exp_res.span_max_depth, span_max_depth);
					error_count++;
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		error_count  = 0;
		idle_on      = 1'b1;
		arst_n       = 1'b0;
		start        = 1'b0;
		action       = ACT_WRITE;
		column       = '0;
		wall_depth   = '0;
		span_left    = '0;
		span_right   = '0;
		sprite_depth = '0;
		for (int c = 0; c < LEAVES; c++)
			col_depth[c] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_tree();
		test_column_writes();
		test_span_clipping();
		test_random_traffic(400);

		start <= 1'b0;
		while (pending_occlusions.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
